// ----- rtl/s20ks_pkg.sv -----
package s20ks_pkg;

  localparam int unsigned NumWords     = 16;
  localparam int unsigned WordIdxW     = $clog2(NumWords);
  localparam int unsigned DoubleRounds = 10;
  localparam int unsigned CfgIdxW      = 8;

  typedef struct packed {
    logic                gen;
    logic                rd;
    logic [WordIdxW-1:0] rd_addr;
  } core_req_t;

  typedef struct packed {
    logic                done;
    logic [WordIdxW-1:0] init_idx;
  } core_rsp_t;

  // word indices {a, b, c, d} of each quarter round in a double round
  function automatic logic [4*WordIdxW-1:0] qr_sel(input logic [2:0] n);
    logic [4*WordIdxW-1:0] r;
    case (n)
      3'd0:    r = {4'd0,  4'd4,  4'd8,  4'd12};
      3'd1:    r = {4'd5,  4'd9,  4'd13, 4'd1};
      3'd2:    r = {4'd10, 4'd14, 4'd2,  4'd6};
      3'd3:    r = {4'd15, 4'd3,  4'd7,  4'd11};
      3'd4:    r = {4'd0,  4'd1,  4'd2,  4'd3};
      3'd5:    r = {4'd5,  4'd6,  4'd7,  4'd4};
      3'd6:    r = {4'd10, 4'd11, 4'd8,  4'd9};
      3'd7:    r = {4'd15, 4'd12, 4'd13, 4'd14};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/s20ks_core.sv -----
module s20ks_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  s20ks_pkg::core_req_t   req_i,
  input  logic [31:0]            init_word_i,
  output s20ks_pkg::core_rsp_t   rsp_o,
  output logic [31:0]            rd_data_o
);
  import s20ks_pkg::*;

  localparam int unsigned QrPerDouble = 8;
  localparam int unsigned QrTotal     = DoubleRounds * QrPerDouble;
  localparam int unsigned QrCntW      = $clog2(QrTotal);
  localparam logic [QrCntW-1:0] QrLast = QrCntW'(QrTotal - 1);
  localparam int unsigned CntW        = $clog2(NumWords + 1);
  localparam logic [CntW-1:0] CntEnd  = CntW'(NumWords);
  localparam logic [CntW-1:0] CntLast = CntW'(NumWords - 1);

  localparam logic [1:0] StepB = 2'd0;
  localparam logic [1:0] StepC = 2'd1;
  localparam logic [1:0] StepD = 2'd2;
  localparam logic [1:0] StepA = 2'd3;

  localparam int unsigned RotB = 7;
  localparam int unsigned RotC = 9;
  localparam int unsigned RotD = 13;
  localparam int unsigned RotA = 18;

  typedef enum logic [2:0] {
    C_IDLE, C_LOAD, C_RDAB, C_RDCD, C_CAP, C_CALC, C_WB, C_FF
  } cstate_e;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  cstate_e             state_q;
  logic [CntW-1:0]     cnt_q;
  logic [QrCntW-1:0]   qr_q;
  logic [1:0]          step_q;
  logic [31:0]         qa_q, qb_q, qc_q, qd_q;
  logic [31:0]         rd0_q, rd1_q;
  logic [31:0]         mem [NumWords];

  logic [4*WordIdxW-1:0] sel;
  logic [WordIdxW-1:0]   idx_a, idx_b, idx_c, idx_d;
  logic [CntW-1:0]       cnt_m1;
  logic [WordIdxW-1:0]   ff_idx;
  logic [31:0]           op_x, op_y, op_z, sum, rot, step_res;
  logic                  we;
  logic [WordIdxW-1:0]   wa;
  logic [31:0]           wd;
  logic                  rd0_en, rd1_en;
  logic [WordIdxW-1:0]   rd0_addr, rd1_addr;

  assign sel    = qr_sel(qr_q[2:0]);
  assign idx_a  = sel[4*WordIdxW-1:3*WordIdxW];
  assign idx_b  = sel[3*WordIdxW-1:2*WordIdxW];
  assign idx_c  = sel[2*WordIdxW-1:WordIdxW];
  assign idx_d  = sel[WordIdxW-1:0];
  assign cnt_m1 = cnt_q - CntW'(1);
  assign ff_idx = cnt_m1[WordIdxW-1:0];

  assign rsp_o.done     = (state_q == C_FF) && (cnt_q == CntEnd);
  assign rsp_o.init_idx = (state_q == C_LOAD) ? cnt_q[WordIdxW-1:0] : ff_idx;
  assign rd_data_o      = rd0_q;

  // shared quarter-round step: x ^= rotl(y + z, r)
  always_comb begin
    case (step_q)
      StepB:   begin op_x = qb_q; op_y = qa_q; op_z = qd_q; end
      StepC:   begin op_x = qc_q; op_y = qb_q; op_z = qa_q; end
      StepD:   begin op_x = qd_q; op_y = qc_q; op_z = qb_q; end
      StepA:   begin op_x = qa_q; op_y = qd_q; op_z = qc_q; end
      default: begin op_x = qa_q; op_y = qd_q; op_z = qc_q; end
    endcase
    sum = op_y + op_z;
    case (step_q)
      StepB:   rot = rotl32(sum, RotB);
      StepC:   rot = rotl32(sum, RotC);
      StepD:   rot = rotl32(sum, RotD);
      StepA:   rot = rotl32(sum, RotA);
      default: rot = rotl32(sum, RotA);
    endcase
    step_res = op_x ^ rot;
  end

  always_comb begin
    we       = 1'b0;
    wa       = cnt_q[WordIdxW-1:0];
    wd       = init_word_i;
    rd0_en   = 1'b0;
    rd0_addr = idx_a;
    rd1_en   = 1'b0;
    rd1_addr = idx_b;
    case (state_q)
      C_IDLE: begin
        rd0_en   = req_i.rd;
        rd0_addr = req_i.rd_addr;
      end
      C_LOAD: begin
        we = 1'b1;
      end
      C_RDAB: begin
        rd0_en = 1'b1;
        rd1_en = 1'b1;
      end
      C_RDCD: begin
        rd0_en   = 1'b1;
        rd0_addr = idx_c;
        rd1_en   = 1'b1;
        rd1_addr = idx_d;
      end
      C_WB: begin
        we = 1'b1;
        case (step_q)
          StepB:   begin wa = idx_b; wd = qb_q; end
          StepC:   begin wa = idx_c; wd = qc_q; end
          StepD:   begin wa = idx_d; wd = qd_q; end
          StepA:   begin wa = idx_a; wd = qa_q; end
          default: begin wa = idx_a; wd = qa_q; end
        endcase
      end
      C_FF: begin
        // read word i while word i-1 gets its feed-forward add
        rd0_en   = (cnt_q < CntEnd);
        rd0_addr = cnt_q[WordIdxW-1:0];
        we       = (cnt_q != '0);
        wa       = ff_idx;
        wd       = rd0_q + init_word_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd0_en) begin
      rd0_q <= mem[rd0_addr];
    end
    if (rd1_en) begin
      rd1_q <= mem[rd1_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      C_RDCD: begin
        qa_q <= rd0_q;
        qb_q <= rd1_q;
      end
      C_CAP: begin
        qc_q <= rd0_q;
        qd_q <= rd1_q;
      end
      C_CALC: begin
        case (step_q)
          StepB:   qb_q <= step_res;
          StepC:   qc_q <= step_res;
          StepD:   qd_q <= step_res;
          StepA:   qa_q <= step_res;
          default: qa_q <= step_res;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      cnt_q   <= '0;
      qr_q    <= '0;
      step_q  <= '0;
    end else begin
      case (state_q)
        C_IDLE: begin
          if (req_i.gen) begin
            state_q <= C_LOAD;
            cnt_q   <= '0;
          end
        end
        C_LOAD: begin
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == CntLast) begin
            state_q <= C_RDAB;
            qr_q    <= '0;
          end
        end
        C_RDAB: state_q <= C_RDCD;
        C_RDCD: state_q <= C_CAP;
        C_CAP: begin
          state_q <= C_CALC;
          step_q  <= '0;
        end
        C_CALC: begin
          step_q <= step_q + 2'd1;
          if (step_q == StepA) begin
            state_q <= C_WB;
          end
        end
        C_WB: begin
          step_q <= step_q + 2'd1;
          if (step_q == StepA) begin
            if (qr_q == QrLast) begin
              state_q <= C_FF;
              cnt_q   <= '0;
            end else begin
              state_q <= C_RDAB;
              qr_q    <= qr_q + QrCntW'(1);
            end
          end
        end
        C_FF: begin
          cnt_q <= cnt_q + CntW'(1);
          if (cnt_q == CntEnd) begin
            state_q <= C_IDLE;
          end
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/salsa20_keystream_xor_top.sv -----
// salsa20/20 keystream xor, one byte per transaction
//
// input channel: in_valid_i/in_ready_o carries data_byte_i, message_start_i and
// block_offset_i. output channel: out_valid_o/out_ready_i carries out_byte_o and
// counter_overflow_o. config channel: cfg_valid_i/cfg_ready_o writes cfg_data_i
// into state register cfg_index_i (0..7, others ignored); cfg_ready_o is always
// high, write only while the block is idle.
// a byte inside a keystream block passes the read and output states to out_valid_o,
// and the next byte can be accepted once the block is idle again. a byte that
// needs a new block (message start, first byte after reset, every 64th byte) first
// waits for the block: after the request and the state load, one quarter-round
// step unit runs 80 quarter rounds on a 16-word memory, then a feed-forward pass
// adds the state back before the byte read.
// reset clears the config registers, counter, position and overflow flag; the
// first byte after reset starts a message.
// the result sits in an output register; a stalled receiver holds it there while
// the next byte is accepted and worked on, and that byte waits for the slot.
module salsa20_keystream_xor_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          message_start_i,
  input  logic [63:0]                   block_offset_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    out_byte_o,
  output logic                          counter_overflow_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [s20ks_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]                   cfg_data_i
);
  import s20ks_pkg::*;

  localparam int unsigned NumRegs = NumWords / 2;
  localparam int unsigned RegIdxW = $clog2(NumRegs);
  localparam logic [RegIdxW-1:0] RegBaseCounter = RegIdxW'(4);

  typedef enum logic [2:0] {ST_IDLE, ST_KICK, ST_WAIT, ST_READ, ST_OUT} state_e;

  state_e       state_q;
  logic [63:0]  regs_q [NumRegs];
  logic         started_q;
  logic [5:0]   pos_q;
  logic [63:0]  ctr_q;
  logic         ovf_q;
  logic         out_valid_q;
  logic [7:0]   data_q;
  logic [7:0]   out_byte_q;
  logic         out_ovf_q;

  core_req_t    core_req;
  core_rsp_t    core_rsp;
  logic [31:0]  init_word;
  logic [31:0]  rd_data;
  logic [RegIdxW-1:0] reg_sel;
  logic [63:0]  init_reg;
  logic         accept;
  logic         is_start;
  logic [64:0]  start_sum;
  logic [63:0]  ctr_inc;
  logic         slot_free;
  logic         out_load;
  logic [7:0]   key_byte;

  assign in_ready_o         = (state_q == ST_IDLE);
  assign cfg_ready_o        = 1'b1;
  assign out_valid_o        = out_valid_q;
  assign out_byte_o         = out_byte_q;
  assign counter_overflow_o = out_ovf_q;

  assign accept    = in_valid_i && in_ready_o;
  assign is_start  = message_start_i || !started_q;
  assign start_sum = {1'b0, regs_q[RegBaseCounter]} + {1'b0, block_offset_i};
  assign ctr_inc   = ctr_q + 64'd1;
  assign slot_free = !out_valid_q || out_ready_i;
  assign out_load  = (state_q == ST_OUT) && slot_free;
  assign key_byte  = 8'(rd_data >> {pos_q[1:0], 3'b000});

  // words 8 and 9 come from the running block counter
  assign reg_sel   = core_rsp.init_idx[WordIdxW-1:1];
  assign init_reg  = (reg_sel == RegBaseCounter) ? ctr_q : regs_q[reg_sel];
  assign init_word = core_rsp.init_idx[0] ? init_reg[63:32] : init_reg[31:0];

  assign core_req.gen     = (state_q == ST_KICK);
  assign core_req.rd      = (state_q == ST_READ);
  assign core_req.rd_addr = pos_q[5:2];

  s20ks_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (core_req),
    .init_word_i (init_word),
    .rsp_o       (core_rsp),
    .rd_data_o   (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        regs_q[i] <= '0;
      end
    end else if (cfg_valid_i && (cfg_index_i < CfgIdxW'(NumRegs))) begin
      regs_q[cfg_index_i[RegIdxW-1:0]] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_byte_i;
    end
    if (out_load) begin
      out_byte_q <= data_q ^ key_byte;
      out_ovf_q  <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      started_q   <= 1'b0;
      pos_q       <= '0;
      ctr_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            started_q <= 1'b1;
            if (is_start) begin
              ctr_q   <= start_sum[63:0];
              ovf_q   <= start_sum[64];
              pos_q   <= '0;
              state_q <= ST_KICK;
            end else if (pos_q == '0) begin
              ctr_q <= ctr_inc;
              if (ctr_inc == '0) begin
                ovf_q <= 1'b1;
              end
              state_q <= ST_KICK;
            end else begin
              state_q <= ST_READ;
            end
          end
        end
        ST_KICK: state_q <= ST_WAIT;
        ST_WAIT: begin
          if (core_rsp.done) begin
            state_q <= ST_READ;
          end
        end
        ST_READ: state_q <= ST_OUT;
        ST_OUT: begin
          if (slot_free) begin
            pos_q   <= pos_q + 6'd1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_done_while_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_rsp.done |-> (state_q == ST_WAIT))
    else $error("keystream block finished while nobody waits for it");

  a_gen_at_block_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_KICK) |-> (pos_q == '0))
    else $error("new block requested in the middle of a block");

  a_out_from_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_OUT))
    else $error("result appeared without a keystream read");

  a_start_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && message_start_i) |=> ((pos_q == '0) && (state_q == ST_KICK)))
    else $error("message start did not restart position and block");
`endif

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import s20ks_pkg::*;

  localparam int unsigned NumStateRegs = 8;
  localparam int unsigned RegBaseCtr   = 4;
  localparam int unsigned BlockBytes   = 64;
  localparam int unsigned PhaseBytes   = 212;
  localparam int unsigned NumPhases    = 8;

  typedef enum int {
    CFG_ZERO,
    CFG_ONES,
    CFG_RANDOM,
    CFG_NEAR_WRAP
  } cfg_pattern_e;

  typedef struct packed {
    logic [7:0] xor_byte;
    logic       ovf;
  } xor_result_t;

  class salsa_xor_scoreboard;
    bit [63:0]   state_regs[NumStateRegs];
    bit [7:0]    keystream[BlockBytes];
    bit [5:0]    byte_pos;
    bit [63:0]   blk_ctr;
    bit          ovf_flag;
    bit          msg_open;
    bit [31:0]   mix[16];
    xor_result_t pending_xor_bytes[$];
    int          errors;
    int          checked;
    int          messages;
    int          blocks;
    int          ovf_results;

    function void report_mismatch(string msg);
      errors++;
      if (errors <= 100) $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    function void write_reg(bit [CfgIdxW-1:0] idx, bit [63:0] val);
      if (idx < NumStateRegs) state_regs[idx] = val;
    endfunction

    function bit [31:0] rotl32(bit [31:0] v, int unsigned s);
      return (v << s) | (v >> (32 - s));
    endfunction

    function void salsa_qr(int a, int b, int c, int d);
      mix[b] ^= rotl32(mix[a] + mix[d], 7);
      mix[c] ^= rotl32(mix[b] + mix[a], 9);
      mix[d] ^= rotl32(mix[c] + mix[b], 13);
      mix[a] ^= rotl32(mix[d] + mix[c], 18);
    endfunction

    function void generate_keystream_block();
      bit [31:0] init[16];
      bit [63:0] r;
      bit [31:0] v;
      for (int i = 0; i < NumStateRegs; i++) begin
        r = (i == RegBaseCtr) ? blk_ctr : state_regs[i];
        init[2*i]   = r[31:0];
        init[2*i+1] = r[63:32];
      end
      mix = init;
      for (int n = 0; n < DoubleRounds; n++) begin
        salsa_qr(0, 4, 8, 12);
        salsa_qr(5, 9, 13, 1);
        salsa_qr(10, 14, 2, 6);
        salsa_qr(15, 3, 7, 11);
        salsa_qr(0, 1, 2, 3);
        salsa_qr(5, 6, 7, 4);
        salsa_qr(10, 11, 8, 9);
        salsa_qr(15, 12, 13, 14);
      end
      for (int i = 0; i < 16; i++) begin
        v = mix[i] + init[i];
        for (int j = 0; j < 4; j++) keystream[4*i+j] = v[8*j +: 8];
      end
      blocks++;
    endfunction

    function void take_input_byte(bit [7:0] d, bit s, bit [63:0] off);
      xor_result_t r;
      if (s || !msg_open) begin
        msg_open = 1'b1;
        blk_ctr  = state_regs[RegBaseCtr] + off;
        ovf_flag = blk_ctr < off;
        byte_pos = '0;
        messages++;
        generate_keystream_block();
      end else if (byte_pos == 0) begin
        blk_ctr++;
        if (blk_ctr == 0) ovf_flag = 1'b1;
        generate_keystream_block();
      end
      r.xor_byte = d ^ keystream[byte_pos];
      r.ovf      = ovf_flag;
      pending_xor_bytes.push_back(r);
      byte_pos++;
    endfunction

    function void check_output_byte(logic [7:0] b, logic o);
      xor_result_t e;
      checked++;
      if (o === 1'b1) ovf_results++;
      if (pending_xor_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected output byte %02h", b));
        return;
      end
      e = pending_xor_bytes.pop_front();
      if (b !== e.xor_byte)
        report_mismatch($sformatf("out_byte %02h, expected %02h", b, e.xor_byte));
      if (o !== e.ovf)
        report_mismatch($sformatf("counter_overflow %b, expected %b", o, e.ovf));
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [7:0]          data_byte_i = '0;
  logic                message_start_i = 1'b0;
  logic [63:0]         block_offset_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [7:0]          out_byte_o;
  logic                counter_overflow_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [63:0]         cfg_data_i = '0;

  salsa_xor_scoreboard sb = new();
  bit                  quiet;
  int                  bytes_sent;
  int                  cfg_writes;
  int                  msg_left;

  salsa20_keystream_xor_top DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .data_byte_i,
    .message_start_i,
    .block_offset_i,
    .out_valid_o,
    .out_ready_i,
    .out_byte_o,
    .counter_overflow_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_byte(input logic [7:0] d, input logic s, input logic [63:0] off);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    data_byte_i     = d;
    message_start_i = s;
    block_offset_i  = off;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_input_byte(d, s, off);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    cfg_writes++;
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i = 1'b0;
    while (sb.pending_xor_bytes.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic load_state(input cfg_pattern_e pat);
    logic [63:0] val;
    for (int i = 0; i < NumStateRegs; i++) begin
      case (pat)
        CFG_ZERO: val = '0;
        CFG_ONES: val = '1;
        CFG_NEAR_WRAP: begin
          val = (i == RegBaseCtr) ? 64'd0 - 64'($urandom_range(1, 3)) : rand64();
        end
        default: val = rand64();
      endcase
      write_reg(i[CfgIdxW-1:0], val);
    end
    // out-of-range index, must leave the state alone
    write_reg(CfgIdxW'($urandom_range(NumStateRegs, 2**CfgIdxW - 1)), rand64());
    cfg_valid_i = 1'b0;
  endtask

  task automatic next_random_byte();
    logic [63:0] off;
    logic        s;
    int          r;
    off = rand64();
    s   = 1'b0;
    if (msg_left == 0) begin
      s = 1'b1;
      r = $urandom_range(0, 19);
      if (r < 3) msg_left = $urandom_range(1, 4);
      else if (r < 15) msg_left = $urandom_range(1, 70);
      else msg_left = $urandom_range(64, 200);
      case ($urandom_range(0, 9))
        0: off = '0;
        1: off = 64'($urandom_range(0, 3));
        2: off = '1;
        3, 4: begin
          // land the counter at or just below the wrap point
          off = 64'd0 - sb.state_regs[RegBaseCtr] - 64'($urandom_range(0, 2));
          msg_left = $urandom_range(60, 140);
        end
        default: ;
      endcase
    end
    send_byte(8'($urandom_range(0, 255)), s, off);
    msg_left--;
  endtask

  initial begin
    logic [63:0] base;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    quiet = 1'b0;
    load_state(CFG_NEAR_WRAP);
    base = sb.state_regs[RegBaseCtr];
    // first byte after reset starts a message without the start flag
    send_byte(8'h00, 1'b0, ~base);
    send_byte(8'hFF, 1'b0, '1);
    send_byte(8'h01, 1'b0, '0);
    // start sum overflows, flag sticks for the message
    send_byte(8'hA5, 1'b1, '1);
    send_byte(8'h5A, 1'b0, '0);
    send_byte(8'h80, 1'b1, '0);
    // sum wraps exactly to zero
    send_byte(8'h7F, 1'b1, 64'd0 - base);
    send_byte(8'hC3, 1'b0, rand64());
    send_byte(8'h3C, 1'b1, 64'd1);
    send_byte(8'hFE, 1'b0, '0);
    send_byte(8'h55, 1'b1, 64'h8000_0000_0000_0000);
    send_byte(8'hAA, 1'b0, '1);

    msg_left = 0;
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      quiet = (p % 3 == 2);
      if (p == 0) load_state(CFG_ZERO);
      else if (p == 1) load_state(CFG_ONES);
      else load_state(cfg_pattern_e'($urandom_range(CFG_RANDOM, CFG_NEAR_WRAP)));
      for (int i = 0; i < PhaseBytes; i++) next_random_byte();
    end

    settle();
    repeat (20) @(negedge clk_i);
    $display("run covered %0d bytes in %0d messages, %0d keystream blocks, %0d register writes",
             bytes_sent, sb.messages, sb.blocks, cfg_writes);
    $display("%0d results carried the overflow flag, %0d mismatches",
             sb.ovf_results, sb.errors);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    int gap;
    int holds;
    holds = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      // long receiver stall so the block fills up and pushes back
      if (holds < 2 && sb.checked == (holds == 0 ? 300 : 1100)) begin
        out_ready_i = 1'b0;
        repeat (2500) @(negedge clk_i);
        holds++;
      end
      gap = quiet ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
        out_ready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_output_byte(out_byte_o, counter_overflow_o);
      @(negedge clk_i);
    end
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
